@@ rtl/rotation_matrix_between_vectors_assert.svh @@
// assertion macros shared by the rotation matrix rtl
`ifndef ROTATION_MATRIX_BETWEEN_VECTORS_ASSERT_SVH
`define ROTATION_MATRIX_BETWEEN_VECTORS_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RMBV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rmbv assertion failed");

// next-cycle implication, checked out of reset
`define RMBV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rmbv assertion failed");

`endif

@@ rtl/rmbv_pkg.sv @@
// package: widths, constants, sideband types and helpers for the rotation matrix block
`default_nettype none
package rmbv_pkg;

	localparam int COMP_WIDTH_DEF = 16;
	localparam int SRC_W      = 32;
	localparam int PRE_W      = 16;
	localparam int MAX_SHIFT  = 16;
	localparam int SH_W       = 5;
	localparam int PROD_W     = 32;
	localparam int C_W        = 33;
	localparam int D_W        = 34;
	localparam int MAG_W      = 34;
	localparam int SQ_W       = 64;
	localparam int ROOT_W     = 32;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_QW     = 31;
	localparam int REM_W      = 33;
	localparam int NUM_W      = MAG_W + 32;
	localparam int DIV_LAT    = DIV_QW + 1;
	localparam int FIX_W      = 32;
	localparam int OM_W       = 33;
	localparam int WIDE_W     = 64;
	localparam int ENT_W      = 35;
	localparam int OUT_W      = 16;

	localparam logic signed [OUT_W-1:0]  ONE_Q14 = 16'sd16384;
	localparam logic signed [OUT_W-1:0]  ZERO_Q14 = 16'sd0;
	localparam logic signed [OUT_W-1:0]  SAT_HI = 16'sh7fff;
	localparam logic signed [OUT_W-1:0]  SAT_LO = 16'sh8000;
	localparam logic signed [OM_W-1:0]   ONE_Q30 = 33'sh0_4000_0000;
	localparam logic signed [WIDE_W-1:0] RND30 = 64'sh2000_0000;
	localparam logic signed [ENT_W-1:0]  RND16 = 35'sd32768;
	localparam logic signed [ENT_W-1:0]  ENT_HI = 35'sd32767;
	localparam logic signed [ENT_W-1:0]  ENT_LO = -35'sd32768;

	typedef struct packed {
		logic       deg;
		logic       neg_d;
		logic [2:0] neg_c;
	} side_t;

	typedef struct packed {
		logic [MAG_W-1:0]      d;
		logic [2:0][MAG_W-1:0] c;
	} mags_t;

	function automatic logic fits16(input logic signed [SRC_W-1:0] v);
		return (v[SRC_W-1:PRE_W-1] == '0) || (v[SRC_W-1:PRE_W-1] == '1);
	endfunction

	// smallest right shift that brings all three components into 16 bits
	function automatic logic [SH_W-1:0] pre_shift(input logic signed [SRC_W-1:0] x,
		input logic signed [SRC_W-1:0] y, input logic signed [SRC_W-1:0] z);
		logic [SH_W-1:0] sel;
		logic signed [SRC_W-1:0] tx, ty, tz;
		sel = SH_W'(MAX_SHIFT);
		for (int s = MAX_SHIFT; s >= 0; s--) begin
			tx = x >>> s;
			ty = y >>> s;
			tz = z >>> s;
			if (fits16(tx) && fits16(ty) && fits16(tz)) begin
				sel = SH_W'(s);
			end
		end
		return sel;
	endfunction

	// round half up, drop 30 fraction bits
	function automatic logic signed [WIDE_W-1:0] rs30(input logic signed [WIDE_W-1:0] x);
		return (x + RND30) >>> 30;
	endfunction

	// q1.30-scaled entry to saturated q2.14
	function automatic logic signed [OUT_W-1:0] q14_sat(input logic signed [ENT_W-1:0] e);
		logic signed [ENT_W-1:0] r;
		r = (e + RND16) >>> 16;
		if (r > ENT_HI) begin
			return SAT_HI;
		end else if (r < ENT_LO) begin
			return SAT_LO;
		end
		return r[OUT_W-1:0];
	endfunction

endpackage
`default_nettype wire

@@ rtl/rmbv_isqrt.sv @@
// pipelined 64-bit floor square root, one result bit per stage
`default_nettype none
module rmbv_isqrt
	import rmbv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [SQ_W-1:0]   rad,
	output logic              out_valid,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_W-1:0] rad_s  [SQRT_STEPS+1];
	logic [SQ_W-1:0] root_s [SQRT_STEPS+1];
	logic            vld_s  [SQRT_STEPS+1];

	assign rad_s[0]  = rad;
	assign root_s[0] = '0;
	assign vld_s[0]  = in_valid;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
		localparam logic [SQ_W-1:0] BIT = 64'h1 << (62 - 2 * g);
		logic [SQ_W-1:0] trial;
		logic            take;

		assign trial = root_s[g] + BIT;
		assign take  = rad_s[g] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (take) begin
				rad_s[g+1]  <= rad_s[g] - trial;
				root_s[g+1] <= (root_s[g] >> 1) + BIT;
			end else begin
				rad_s[g+1]  <= rad_s[g];
				root_s[g+1] <= root_s[g] >> 1;
			end
		end
	end

	assign out_valid = vld_s[SQRT_STEPS];
	assign root      = root_s[SQRT_STEPS][ROOT_W-1:0];

endmodule
`default_nettype wire

@@ rtl/rmbv_div.sv @@
// pipelined rounding divider: round(mag * 2^30 / den), one quotient bit per stage
`default_nettype none
module rmbv_div
	import rmbv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [MAG_W-1:0]  mag,
	input  logic [ROOT_W-1:0] den,
	output logic              out_valid,
	output logic [DIV_QW-1:0] quo
);

	logic [NUM_W-1:0]  numer;
	logic [REM_W-1:0]  rem_s [DIV_QW+1];
	logic [DIV_QW-1:0] low_s [DIV_QW+1];
	logic [REM_W-1:0]  dv_s  [DIV_QW+1];
	logic [DIV_QW-1:0] quo_s [DIV_QW+1];
	logic              vld_s [DIV_QW+1];

	// (2*mag*2^30 + den) / (2*den) gives the half-away rounding
	assign numer = ({32'd0, mag} << DIV_QW) + NUM_W'(den);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0] <= numer[DIV_QW +: REM_W];
		low_s[0] <= numer[DIV_QW-1:0];
		dv_s[0]  <= {den, 1'b0};
		quo_s[0] <= '0;
	end

	for (genvar g = 0; g < DIV_QW; g++) begin : g_step
		logic [REM_W:0] trial;
		logic [REM_W:0] diff;
		logic           take;

		assign trial = {rem_s[g], low_s[g][DIV_QW-1-g]};
		assign diff  = trial - {1'b0, dv_s[g]};
		assign take  = trial >= {1'b0, dv_s[g]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1] <= take ? diff[REM_W-1:0] : trial[REM_W-1:0];
			low_s[g+1] <= low_s[g];
			dv_s[g+1]  <= dv_s[g];
			quo_s[g+1] <= {quo_s[g][DIV_QW-2:0], take};
		end
	end

	assign out_valid = vld_s[DIV_QW];
	assign quo       = quo_s[DIV_QW];

endmodule
`default_nettype wire

@@ rtl/rmbv_delay.sv @@
// fixed-depth delay line for data that rides beside the arithmetic units
`default_nettype none
module rmbv_delay
	import rmbv_pkg::*;
#(
	parameter int W     = 1,
	parameter int DEPTH = SQRT_STEPS
) (
	input  logic         clk,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [DEPTH+1];

	assign tap_s[0] = din;

	for (genvar g = 0; g < DEPTH; g++) begin : g_tap
		always_ff @(posedge clk) begin
			tap_s[g+1] <= tap_s[g];
		end
	end

	assign dout = tap_s[DEPTH];

endmodule
`default_nettype wire

@@ rtl/rotation_matrix_between_vectors.sv @@
// top level: rodrigues rotation matrix between two integer vectors, fully pipelined
`default_nettype none
`include "rotation_matrix_between_vectors_assert.svh"
// usage
// - input channel: a transaction is taken at a rising edge with start high and busy low;
//   busy never rises, so a new vector pair may enter on every cycle
// - each pair gives one result transaction: done is high for exactly one cycle while
//   m00..m22 (q2.14, 16384 is one) and degenerate are on the ports
// - pipeline: before done is raised, a pair passes through 5 front stages, the
//   32-stage square root, the 32-stage divider, 5 back stages and the output
//   register
// - throughput: one pair per cycle; the bit-per-stage square root and divider are
//   pipelined, so every stage takes a new item each clock
// - the receiver cannot stall; results are never held, and nothing inside ever waits
// - degenerate pairs (a zero vector, or parallel / antiparallel vectors) give the
//   identity with degenerate set
// - reset: arst_n low clears all valid bits at once; work in flight is dropped and no
//   done is given for it
module rotation_matrix_between_vectors
	import rmbv_pkg::*;
#(
	parameter int COMP_WIDTH = COMP_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COMP_WIDTH-1:0] from_x,
	input  logic signed [COMP_WIDTH-1:0] from_y,
	input  logic signed [COMP_WIDTH-1:0] from_z,
	input  logic signed [COMP_WIDTH-1:0] to_x,
	input  logic signed [COMP_WIDTH-1:0] to_y,
	input  logic signed [COMP_WIDTH-1:0] to_z,
	output logic                         done,
	output logic signed [OUT_W-1:0]      m00,
	output logic signed [OUT_W-1:0]      m01,
	output logic signed [OUT_W-1:0]      m02,
	output logic signed [OUT_W-1:0]      m10,
	output logic signed [OUT_W-1:0]      m11,
	output logic signed [OUT_W-1:0]      m12,
	output logic signed [OUT_W-1:0]      m20,
	output logic signed [OUT_W-1:0]      m21,
	output logic signed [OUT_W-1:0]      m22,
	output logic                         degenerate
);

	// ---------------- front: prescale, products, cross/dot, squared norms ----------------

	logic signed [SRC_W-1:0] fa [3];
	logic signed [SRC_W-1:0] ta [3];
	logic [SH_W-1:0]         sh_a, sh_b;
	logic                    take;

	// the pipeline never stalls, so the input side is always open
	assign busy = 1'b0;
	assign take = start && !busy;

	assign fa[0] = SRC_W'(from_x);
	assign fa[1] = SRC_W'(from_y);
	assign fa[2] = SRC_W'(from_z);
	assign ta[0] = SRC_W'(to_x);
	assign ta[1] = SRC_W'(to_y);
	assign ta[2] = SRC_W'(to_z);

	// each vector gets its own floor shift; always zero at 16-bit components
	assign sh_a = pre_shift(fa[0], fa[1], fa[2]);
	assign sh_b = pre_shift(ta[0], ta[1], ta[2]);

	logic signed [PRE_W-1:0]  a_s1 [3];
	logic signed [PRE_W-1:0]  b_s1 [3];
	logic signed [PROD_W-1:0] ab_s2 [3][3];
	logic signed [PROD_W-1:0] aa_s2 [3];
	logic signed [PROD_W-1:0] bb_s2 [3];
	logic signed [C_W-1:0]    c_s3 [3];
	logic signed [D_W-1:0]    d_s3;
	logic [PROD_W-1:0]        na2_s3, nb2_s3;
	logic                     deg_s3;
	logic signed [C_W-1:0]    c_s4 [3];
	logic signed [D_W-1:0]    d_s4;
	logic [SQ_W-1:0]          pp_s4;
	logic [SQ_W-1:0]          csq_s4 [3];
	logic                     deg_s4;
	logic signed [C_W-1:0]    c_s5 [3];
	logic signed [D_W-1:0]    d_s5;
	logic [SQ_W-1:0]          pp_s5, cc_s5;
	logic                     deg_s5;
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5;

	logic signed [C_W-1:0]    c_nxt [3];
	logic                     deg_nxt;
	logic signed [2*C_W-1:0]  csq_full [3];

	always_comb begin
		c_nxt[0] = C_W'(ab_s2[1][2]) - C_W'(ab_s2[2][1]);
		c_nxt[1] = C_W'(ab_s2[2][0]) - C_W'(ab_s2[0][2]);
		c_nxt[2] = C_W'(ab_s2[0][1]) - C_W'(ab_s2[1][0]);
		// no axis: zero vector, parallel or antiparallel
		deg_nxt  = (c_nxt[0] == '0) && (c_nxt[1] == '0) && (c_nxt[2] == '0);
		for (int i = 0; i < 3; i++) begin
			csq_full[i] = c_s3[i] * c_s3[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			a_s1[i] <= PRE_W'(fa[i] >>> sh_a);
			b_s1[i] <= PRE_W'(ta[i] >>> sh_b);
		end
		// stage 2: all the 16x16 products
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				ab_s2[i][j] <= a_s1[i] * b_s1[j];
			end
			aa_s2[i] <= a_s1[i] * a_s1[i];
			bb_s2[i] <= b_s1[i] * b_s1[i];
		end
		// stage 3: cross product, dot product, squared norms
		c_s3   <= c_nxt;
		d_s3   <= D_W'(ab_s2[0][0]) + D_W'(ab_s2[1][1]) + D_W'(ab_s2[2][2]);
		na2_s3 <= $unsigned(aa_s2[0]) + $unsigned(aa_s2[1]) + $unsigned(aa_s2[2]);
		nb2_s3 <= $unsigned(bb_s2[0]) + $unsigned(bb_s2[1]) + $unsigned(bb_s2[2]);
		deg_s3 <= deg_nxt;
		// stage 4: wide squares
		c_s4   <= c_s3;
		d_s4   <= d_s3;
		pp_s4  <= SQ_W'(na2_s3) * SQ_W'(nb2_s3);
		for (int i = 0; i < 3; i++) begin
			csq_s4[i] <= csq_full[i][SQ_W-1:0];
		end
		deg_s4 <= deg_s3;
		// stage 5: |c|^2
		c_s5   <= c_s4;
		d_s5   <= d_s4;
		pp_s5  <= pp_s4;
		cc_s5  <= csq_s4[0] + csq_s4[1] + csq_s4[2];
		deg_s5 <= deg_s4;
	end

	// ---------------- square roots: p = sqrt(|a|^2 |b|^2), nc = |c| ----------------

	logic [ROOT_W-1:0] p_root, nc_root;
	logic              sq_vld, nc_vld;
	mags_t             mags_in, mags_dly;
	side_t             side_in, side_sq, side_dv;

	always_comb begin
		side_in.deg   = deg_s5;
		side_in.neg_d = d_s5[D_W-1];
		mags_in.d     = d_s5[D_W-1] ? MAG_W'(-d_s5) : MAG_W'(d_s5);
		for (int i = 0; i < 3; i++) begin
			side_in.neg_c[i] = c_s5[i][C_W-1];
			mags_in.c[i]     = c_s5[i][C_W-1] ? MAG_W'($unsigned(-c_s5[i]))
				: MAG_W'($unsigned(c_s5[i]));
		end
	end

	rmbv_isqrt u_sqrt_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.rad       (pp_s5),
		.out_valid (sq_vld),
		.root      (p_root)
	);

	rmbv_isqrt u_sqrt_c (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s5),
		.rad       (cc_s5),
		.out_valid (nc_vld),
		.root      (nc_root)
	);

	rmbv_delay #(.W($bits(mags_t)), .DEPTH(SQRT_STEPS)) u_dly_mags (
		.clk  (clk),
		.din  (mags_in),
		.dout (mags_dly)
	);

	rmbv_delay #(.W($bits(side_t)), .DEPTH(SQRT_STEPS)) u_dly_side_sq (
		.clk  (clk),
		.din  (side_in),
		.dout (side_sq)
	);

	// ---------------- dividers: cos, sin and the unit axis in q1.30 ----------------

	logic [DIV_QW-1:0] q_cs, q_sn;
	logic [DIV_QW-1:0] q_k [3];
	logic              dv_vld;

	rmbv_div u_div_cs (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_vld),
		.mag       (mags_dly.d),
		.den       (p_root),
		.out_valid (dv_vld),
		.quo       (q_cs)
	);

	rmbv_div u_div_sn (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sq_vld),
		.mag       (MAG_W'(nc_root)),
		.den       (p_root),
		.out_valid (),
		.quo       (q_sn)
	);

	for (genvar g = 0; g < 3; g++) begin : g_axis
		rmbv_div u_div_k (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (sq_vld),
			.mag       (mags_dly.c[g]),
			.den       (nc_root),
			.out_valid (),
			.quo       (q_k[g])
		);
	end

	rmbv_delay #(.W($bits(side_t)), .DEPTH(DIV_LAT)) u_dly_side_dv (
		.clk  (clk),
		.din  (side_sq),
		.dout (side_dv)
	);

	// ---------------- back: rodrigues terms, rounding, saturation ----------------

	logic signed [FIX_W-1:0]  cs_b0, sn_b0;
	logic signed [FIX_W-1:0]  k_b0 [3];
	logic signed [FIX_W-1:0]  cs_b1, cs_b2, cs_b3;
	logic signed [OM_W-1:0]   om_b1, om_b2;
	logic signed [WIDE_W-1:0] kk_b1 [6];
	logic signed [WIDE_W-1:0] sk_b1 [3];
	logic signed [FIX_W-1:0]  kr_b2 [6];
	logic signed [FIX_W-1:0]  sr_b2 [3];
	logic signed [FIX_W-1:0]  sr_b3 [3];
	logic signed [WIDE_W-1:0] t_b3 [6];
	logic signed [ENT_W-1:0]  e_b4 [9];
	logic                     deg_b0, deg_b1, deg_b2, deg_b3, deg_b4;
	logic                     v_b0, v_b1, v_b2, v_b3, v_b4;
	logic                     done_q;

	logic signed [FIX_W-1:0]  qs_cs;
	logic signed [FIX_W-1:0]  qs_k [3];
	logic signed [WIDE_W:0]   t_full [6];
	logic signed [ENT_W-1:0]  tt [6];
	logic signed [ENT_W-1:0]  sx [3];
	logic signed [ENT_W-1:0]  cx;

	always_comb begin
		qs_cs = $signed({1'b0, q_cs});
		for (int i = 0; i < 3; i++) begin
			qs_k[i] = $signed({1'b0, q_k[i]});
		end
		for (int i = 0; i < 6; i++) begin
			t_full[i] = om_b2 * kr_b2[i];
			tt[i]     = ENT_W'(rs30(t_b3[i]));
		end
		for (int i = 0; i < 3; i++) begin
			sx[i] = ENT_W'(sr_b3[i]);
		end
		cx = ENT_W'(cs_b3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b0   <= 1'b0;
			v_b1   <= 1'b0;
			v_b2   <= 1'b0;
			v_b3   <= 1'b0;
			v_b4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_b0   <= dv_vld;
			v_b1   <= v_b0;
			v_b2   <= v_b1;
			v_b3   <= v_b2;
			v_b4   <= v_b3;
			done_q <= v_b4;
		end
	end

	always_ff @(posedge clk) begin
		// b0: signs back on
		cs_b0  <= side_dv.neg_d ? -qs_cs : qs_cs;
		sn_b0  <= $signed({1'b0, q_sn});
		for (int i = 0; i < 3; i++) begin
			k_b0[i] <= side_dv.neg_c[i] ? -qs_k[i] : qs_k[i];
		end
		deg_b0 <= side_dv.deg;
		// b1: outer product of the axis, sin times axis, 1 - cos
		kk_b1[0] <= k_b0[0] * k_b0[0];
		kk_b1[1] <= k_b0[0] * k_b0[1];
		kk_b1[2] <= k_b0[0] * k_b0[2];
		kk_b1[3] <= k_b0[1] * k_b0[1];
		kk_b1[4] <= k_b0[1] * k_b0[2];
		kk_b1[5] <= k_b0[2] * k_b0[2];
		for (int i = 0; i < 3; i++) begin
			sk_b1[i] <= sn_b0 * k_b0[i];
		end
		om_b1  <= ONE_Q30 - OM_W'(cs_b0);
		cs_b1  <= cs_b0;
		deg_b1 <= deg_b0;
		// b2: back to q1.30
		for (int i = 0; i < 6; i++) begin
			kr_b2[i] <= FIX_W'(rs30(kk_b1[i]));
		end
		for (int i = 0; i < 3; i++) begin
			sr_b2[i] <= FIX_W'(rs30(sk_b1[i]));
		end
		om_b2  <= om_b1;
		cs_b2  <= cs_b1;
		deg_b2 <= deg_b1;
		// b3: (1 - cos) k k^T
		for (int i = 0; i < 6; i++) begin
			t_b3[i] <= $signed(t_full[i][WIDE_W-1:0]);
		end
		sr_b3  <= sr_b2;
		cs_b3  <= cs_b2;
		deg_b3 <= deg_b2;
		// b4: cos on the diagonal, skew term off it
		e_b4[0] <= cx + tt[0];
		e_b4[1] <= tt[1] - sx[2];
		e_b4[2] <= tt[2] + sx[1];
		e_b4[3] <= tt[1] + sx[2];
		e_b4[4] <= cx + tt[3];
		e_b4[5] <= tt[4] - sx[0];
		e_b4[6] <= tt[2] - sx[1];
		e_b4[7] <= tt[4] + sx[0];
		e_b4[8] <= cx + tt[5];
		deg_b4  <= deg_b3;
		// output register: round to q2.14, or the identity when there is no axis
		m00 <= deg_b4 ? ONE_Q14 : q14_sat(e_b4[0]);
		m01 <= deg_b4 ? ZERO_Q14 : q14_sat(e_b4[1]);
		m02 <= deg_b4 ? ZERO_Q14 : q14_sat(e_b4[2]);
		m10 <= deg_b4 ? ZERO_Q14 : q14_sat(e_b4[3]);
		m11 <= deg_b4 ? ONE_Q14 : q14_sat(e_b4[4]);
		m12 <= deg_b4 ? ZERO_Q14 : q14_sat(e_b4[5]);
		m20 <= deg_b4 ? ZERO_Q14 : q14_sat(e_b4[6]);
		m21 <= deg_b4 ? ZERO_Q14 : q14_sat(e_b4[7]);
		m22 <= deg_b4 ? ONE_Q14 : q14_sat(e_b4[8]);
		degenerate <= deg_b4;
	end

	assign done = done_q;

	// ---------------- checks ----------------

	`RMBV_ASSERT_NEXT(a_accept_enters, clk, arst_n, take, v_s1)
	`RMBV_ASSERT_IMPL(a_sqrt_lanes_aligned, clk, arst_n, sq_vld || nc_vld, sq_vld && nc_vld)
	`RMBV_ASSERT_NEXT(a_tail_to_done, clk, arst_n, v_b4, done)
	`RMBV_ASSERT_IMPL(a_degen_identity, clk, arst_n, done && degenerate, m00 == ONE_Q14 && m11 == ONE_Q14 && m22 == ONE_Q14 && m01 == ZERO_Q14 && m12 == ZERO_Q14)

endmodule
`default_nettype wire
